// ----- design/tmq_pkg.sv -----
// ============================================================================
// tmq_pkg
// Shared types and constants for the tile map quad generator.
// ============================================================================
package tmq_pkg;
    localparam int MAX_SETS     = 8;
    localparam int MAX_MAP_SIDE = 4096;
    localparam int SET_W        = $clog2(MAX_SETS);
    localparam int SIDE_W       = $clog2(MAX_MAP_SIDE) + 1;
    localparam int QUAD_VERTS   = 6;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BEGIN = 2'd1;
    localparam logic [1:0] CMD_TILE  = 2'd2;

    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SET_COUNT  = 2'd2;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_MUL,
        BK_EMIT
    } bk_state_t;

    // job handed from front to back
    typedef struct packed {
        logic [SET_W-1:0]  set_index;
        logic [23:0]       seq;
        logic [31:0]       local_id;
        logic [12:0]       columns;
        logic [8:0]        tile_w;
        logic [8:0]        tile_h;
        logic [SIDE_W-2:0] col;
        logic [SIDE_W-1:0] row;
    } tmq_job_t;
endpackage

// ----- design/tmq_front.sv -----
// ============================================================================
// tmq_front
// Accepts items, keeps the tileset table and position, classifies tiles.
// ============================================================================
module tmq_front
    import tmq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_command,
    input  logic [2:0]       s_slot,
    input  logic [31:0]      s_first_id,
    input  logic [31:0]      s_last_id,
    input  logic [12:0]      s_sheet_columns,
    input  logic [8:0]       s_tile_width,
    input  logic [8:0]       s_tile_height,
    input  logic [31:0]      s_tile_id,
    input  logic [12:0]      map_width,
    input  logic [12:0]      map_height,
    input  logic [3:0]       tileset_count,
    output logic             job_valid,
    input  logic             job_ready,
    output tmq_job_t         job
);
    logic [31:0]       first_reg [MAX_SETS];
    logic [31:0]       lastid_reg [MAX_SETS];
    logic [12:0]       cols_reg [MAX_SETS];
    logic [8:0]        tw_reg [MAX_SETS];
    logic [8:0]        th_reg [MAX_SETS];
    logic [23:0]       count_reg [MAX_SETS];
    logic [SIDE_W-2:0] col_reg;
    logic [SIDE_W-1:0] row_reg;
    logic              jv_reg;
    tmq_job_t          job_reg;

    logic [SIDE_W-1:0] eff_w, eff_h;
    logic [4:0]        eff_cnt;
    logic              found;
    logic [SET_W-1:0]  hit;
    logic              accept, in_map, emit;
    logic [SIDE_W-1:0] col_inc;

    assign s_ready   = !jv_reg || job_ready;
    assign accept    = s_valid && s_ready;
    assign job_valid = jv_reg;
    assign job       = job_reg;

    always_comb begin
        eff_w = (map_width == 13'd0) ? SIDE_W'(1) :
                (map_width > 13'(MAX_MAP_SIDE)) ? SIDE_W'(MAX_MAP_SIDE) : SIDE_W'(map_width);
        eff_h = (map_height > 13'(MAX_MAP_SIDE)) ? SIDE_W'(MAX_MAP_SIDE) : SIDE_W'(map_height);
        eff_cnt = (tileset_count > 4'(MAX_SETS)) ? 5'(MAX_SETS) : 5'(tileset_count);
        found = 1'b0;
        hit   = '0;
        for (int i = 0; i < MAX_SETS; i++) begin
            if (5'(i) < eff_cnt && s_tile_id >= first_reg[i] && s_tile_id <= lastid_reg[i]) begin
                found = 1'b1;
                hit   = SET_W'(i);
            end
        end
        in_map  = row_reg < eff_h;
        col_inc = SIDE_W'(col_reg) + SIDE_W'(1);
        emit    = in_map && s_tile_id != 32'd0 && found && cols_reg[hit] != 13'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            jv_reg  <= 1'b0;
            for (int i = 0; i < MAX_SETS; i++) count_reg[i] <= '0;
        end else begin
            if (accept && s_command == CMD_TILE && emit) jv_reg <= 1'b1;
            else if (job_ready) jv_reg <= 1'b0;
            if (accept) begin
                case (s_command)
                    CMD_LOAD: begin
                        if (32'(s_slot) < MAX_SETS) begin
                            first_reg[SET_W'(s_slot)]  <= s_first_id;
                            lastid_reg[SET_W'(s_slot)] <= s_last_id;
                            cols_reg[SET_W'(s_slot)]   <= s_sheet_columns;
                            tw_reg[SET_W'(s_slot)]     <= s_tile_width;
                            th_reg[SET_W'(s_slot)]     <= s_tile_height;
                        end
                    end
                    CMD_BEGIN: begin
                        col_reg <= '0;
                        row_reg <= '0;
                        for (int i = 0; i < MAX_SETS; i++) count_reg[i] <= '0;
                    end
                    CMD_TILE: begin
                        if (in_map) begin
                            if (col_inc >= eff_w) begin
                                col_reg <= '0;
                                row_reg <= row_reg + SIDE_W'(1);
                            end else begin
                                col_reg <= col_inc[SIDE_W-2:0];
                            end
                        end
                        if (emit) begin
                            count_reg[hit]    <= count_reg[hit] + 24'd1;
                            job_reg.set_index <= hit;
                            job_reg.seq       <= count_reg[hit];
                            job_reg.local_id  <= s_tile_id - first_reg[hit];
                            job_reg.columns   <= cols_reg[hit];
                            job_reg.tile_w    <= tw_reg[hit];
                            job_reg.tile_h    <= th_reg[hit];
                            job_reg.col       <= col_reg;
                            job_reg.row       <= row_reg;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

// ----- design/tmq_back.sv -----
// ============================================================================
// tmq_back
// Divides the local id, forms base coordinates and emits six vertices.
// ============================================================================
module tmq_back
    import tmq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             job_valid,
    output logic             job_ready,
    input  tmq_job_t         job,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_set_index,
    output logic [23:0]      m_sequence_res,
    output logic [2:0]       m_corner,
    output logic [20:0]      m_screen_x,
    output logic [20:0]      m_screen_y,
    output logic [32:0]      m_tex_u,
    output logic [32:0]      m_tex_v,
    output logic             m_last
);
    bk_state_t   state_reg, state_next;
    tmq_job_t    job_reg;
    logic [31:0] quo_reg;
    logic [12:0] rem_reg;
    logic [5:0]  bit_reg;
    logic [31:0] tx_reg, ty_reg;
    logic [20:0] px_reg, py_reg;
    logic [2:0]  corner_reg;

    logic [13:0] rem_sh;
    logic        ge;
    logic        dx, dy;
    logic        take, fire;
    logic [SIDE_W+8:0] pxf, pyf;

    assign rem_sh = {rem_reg, quo_reg[31]};
    assign ge     = rem_sh >= {1'b0, job_reg.columns};
    assign fire   = m_valid && m_ready;
    assign pxf    = job_reg.col * job_reg.tile_w;
    assign pyf    = job_reg.row * job_reg.tile_h;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (job_valid) state_next = BK_DIV;
            BK_DIV:  if (bit_reg == 6'd31) state_next = BK_MUL;
            BK_MUL:  state_next = BK_EMIT;
            BK_EMIT: if (fire && corner_reg == 3'(QUAD_VERTS - 1)) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        job_ready = state_reg == BK_IDLE;
        m_valid   = state_reg == BK_EMIT;
        take      = job_ready && job_valid;
        case (corner_reg)
            3'd1:    begin dx = 1'b1; dy = 1'b0; end
            3'd2:    begin dx = 1'b1; dy = 1'b1; end
            3'd4:    begin dx = 1'b1; dy = 1'b1; end
            3'd5:    begin dx = 1'b0; dy = 1'b1; end
            default: begin dx = 1'b0; dy = 1'b0; end
        endcase
        m_set_index    = 3'(job_reg.set_index);
        m_sequence_res = job_reg.seq;
        m_corner       = corner_reg;
        m_screen_x     = px_reg + (dx ? 21'(job_reg.tile_w) : 21'd0);
        m_screen_y     = py_reg + (dy ? 21'(job_reg.tile_h) : 21'd0);
        m_tex_u        = 33'(tx_reg) + (dx ? 33'(job_reg.tile_w) : 33'd0);
        m_tex_v        = 33'(ty_reg) + (dy ? 33'(job_reg.tile_h) : 33'd0);
        m_last         = corner_reg == 3'(QUAD_VERTS - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= BK_IDLE;
            corner_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (take) begin
                job_reg    <= job;
                quo_reg    <= job.local_id;
                rem_reg    <= '0;
                bit_reg    <= '0;
                corner_reg <= '0;
            end
            if (state_reg == BK_DIV) begin
                rem_reg <= ge ? 13'(rem_sh - {1'b0, job_reg.columns}) : rem_sh[12:0];
                quo_reg <= {quo_reg[30:0], ge};
                bit_reg <= bit_reg + 6'd1;
            end
            if (state_reg == BK_MUL) begin
                tx_reg <= 32'(rem_reg * job_reg.tile_w);
                ty_reg <= 32'(quo_reg * job_reg.tile_h);
                px_reg <= pxf[20:0];
                py_reg <= pyf[20:0];
            end
            if (fire) corner_reg <= corner_reg + 3'd1;
        end
    end
endmodule

// ----- design/tile_map_quad_generator_core.sv -----
// ============================================================================
// tile_map_quad_generator_core
// Turns a row-major stream of tile ids into two-triangle screen quads.
// ============================================================================
// Input channel s_*: load-slot, begin-layer and tile items. The front stage
// updates the tileset table and position in the accept cycle and hands an
// emitting tile to a one-entry job register. The back stage runs a radix-2
// divider for local id / columns, one multiply step, then emits six vertices
// on m_*, one per cycle when m_ready is high. A drawn tile holds the back
// stage through the take, the divide, the multiply and the six emits.
// Loads, begin-layer and skipped tiles are taken while the job register is
// free. When m_ready stays low the current vertex holds, the back stage
// waits, and once the job register is full s_ready drops.
// Configuration writes on cfg_* are always taken. Synchronous active-low
// reset restores map 64x64, zero tilesets, zero counters and position, and
// clears both stages; tileset entries are undefined until loaded.
// ============================================================================
module tile_map_quad_generator_core
    import tmq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [2:0]  s_slot,
    input  logic [31:0] s_first_id,
    input  logic [31:0] s_last_id,
    input  logic [12:0] s_sheet_columns,
    input  logic [8:0]  s_tile_width,
    input  logic [8:0]  s_tile_height,
    input  logic [31:0] s_tile_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_set_index,
    output logic [23:0] m_sequence_res,
    output logic [2:0]  m_corner,
    output logic [20:0] m_screen_x,
    output logic [20:0] m_screen_y,
    output logic [32:0] m_tex_u,
    output logic [32:0] m_tex_v,
    output logic        m_last
);
    logic [12:0] width_reg, height_reg;
    logic [3:0]  count_reg;
    logic        job_valid, job_ready;
    tmq_job_t    job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 13'd64;
            height_reg <= 13'd64;
            count_reg  <= 4'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAP_WIDTH:  width_reg  <= cfg_data;
                REG_MAP_HEIGHT: height_reg <= cfg_data;
                REG_SET_COUNT:  count_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    tmq_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command, .s_slot, .s_first_id,
        .s_last_id, .s_sheet_columns, .s_tile_width, .s_tile_height, .s_tile_id,
        .map_width(width_reg), .map_height(height_reg), .tileset_count(count_reg),
        .job_valid, .job_ready, .job
    );

    tmq_back u_back (
        .aclk, .aresetn, .job_valid, .job_ready, .job, .m_valid, .m_ready,
        .m_set_index, .m_sequence_res, .m_corner, .m_screen_x, .m_screen_y,
        .m_tex_u, .m_tex_v, .m_last
    );

    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_corner == 3'd5))) else $error("last flag mismatch");
    a_corner_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (m_valid && m_corner == $past(m_corner) + 3'd1))
        else $error("corner sequence broken");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_sequence_res) && $stable(m_tex_u))
        else $error("vertex changed under stall");
endmodule

// ----- bench/tile_map_quad_generator_core_test.sv -----
// ============================================================================
// tile_map_quad_generator_core_test
// Self-checking bench for the tile map quad generator. It loads tileset
// slots, sets the map size and slot count, and streams tile ids. A scoreboard
// predicts the six vertices of every drawn quad and compares them in order.
// Sender and receiver stall at random in three idle modes.
// ============================================================================
module tile_map_quad_generator_core_test
    import tmq_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  slot;
        logic [31:0] first_id;
        logic [31:0] last_id;
        logic [12:0] sheet_columns;
        logic [8:0]  tile_width;
        logic [8:0]  tile_height;
        logic [31:0] tile_id;
    } tile_item_t;

    typedef struct packed {
        logic [2:0]  set_index;
        logic [23:0] seq;
        logic [2:0]  corner;
        logic [20:0] sx;
        logic [20:0] sy;
        logic [32:0] u;
        logic [32:0] v;
        logic        last;
    } vertex_t;

    class quad_scoreboard;
        bit [12:0] map_w = 64;
        bit [12:0] map_h = 64;
        bit [3:0]  set_count = 0;
        bit [31:0] first_id [MAX_SETS];
        bit [31:0] last_id [MAX_SETS];
        bit [12:0] columns [MAX_SETS];
        bit [8:0]  tile_w [MAX_SETS];
        bit [8:0]  tile_h [MAX_SETS];
        bit [23:0] quad_count [MAX_SETS];
        bit [31:0] col_pos = 0;
        bit [31:0] row_pos = 0;
        vertex_t   pending [$];
        int        errors = 0;

        function new();
            for (int i = 0; i < MAX_SETS; i++) begin
                first_id[i] = 0; last_id[i] = 0; columns[i] = 0;
                tile_w[i] = 0; tile_h[i] = 0; quad_count[i] = 0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [12:0] val);
            case (idx)
                REG_MAP_WIDTH:  map_w = val;
                REG_MAP_HEIGHT: map_h = val;
                REG_SET_COUNT:  set_count = val[3:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_count();
            return (set_count > MAX_SETS) ? MAX_SETS : set_count;
        endfunction

        function void note_input(tile_item_t it);
            bit [31:0] ew, eh, x, y, lid, tx, ty, cnt;
            bit [63:0] px, py, ax, ay;
            int        hit;
            vertex_t   vx;
            case (it.command)
                CMD_LOAD: begin
                    first_id[it.slot] = it.first_id;
                    last_id[it.slot]  = it.last_id;
                    columns[it.slot]  = it.sheet_columns;
                    tile_w[it.slot]   = it.tile_width;
                    tile_h[it.slot]   = it.tile_height;
                end
                CMD_BEGIN: begin
                    col_pos = 0;
                    row_pos = 0;
                    for (int i = 0; i < MAX_SETS; i++) quad_count[i] = 0;
                end
                CMD_TILE: begin
                    ew = (map_w < 1) ? 1 : ((map_w > MAX_MAP_SIDE) ? MAX_MAP_SIDE : map_w);
                    eh = (map_h > MAX_MAP_SIDE) ? MAX_MAP_SIDE : map_h;
                    if (row_pos >= eh) return;
                    x = col_pos;
                    y = row_pos;
                    col_pos++;
                    if (col_pos >= ew) begin
                        col_pos = 0;
                        row_pos++;
                    end
                    if (it.tile_id == 0) return;
                    hit = -1;
                    cnt = eff_count();
                    for (int i = 0; i < cnt; i++)
                        if (it.tile_id >= first_id[i] && it.tile_id <= last_id[i]) hit = i;
                    if (hit < 0 || columns[hit] == 0) return;
                    lid = it.tile_id - first_id[hit];
                    tx = (lid % columns[hit]) * tile_w[hit];
                    ty = (lid / columns[hit]) * tile_h[hit];
                    px = 64'(x) * tile_w[hit];
                    py = 64'(y) * tile_h[hit];
                    for (int c = 0; c < QUAD_VERTS; c++) begin
                        ax = (c == 1 || c == 2 || c == 4) ? 64'(tile_w[hit]) : 64'd0;
                        ay = (c == 2 || c == 4 || c == 5) ? 64'(tile_h[hit]) : 64'd0;
                        vx.set_index = hit[2:0];
                        vx.seq       = quad_count[hit];
                        vx.corner    = c[2:0];
                        vx.sx        = 21'(px + ax);
                        vx.sy        = 21'(py + ay);
                        vx.u         = 33'(64'(tx) + ax);
                        vx.v         = 33'(64'(ty) + ay);
                        vx.last      = (c == QUAD_VERTS - 1);
                        pending = {pending, vx};
                    end
                    quad_count[hit] = quad_count[hit] + 1;
                end
                default: ;
            endcase
        endfunction

        function void check_result(vertex_t got);
            vertex_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected vertex %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.set_index !== want.set_index) begin
                $display("%0t: set_index exp %0d got %0d", $time, want.set_index, got.set_index);
                errors++;
            end
            if (got.seq !== want.seq) begin
                $display("%0t: sequence exp %0d got %0d", $time, want.seq, got.seq);
                errors++;
            end
            if (got.corner !== want.corner) begin
                $display("%0t: corner exp %0d got %0d", $time, want.corner, got.corner);
                errors++;
            end
            if (got.sx !== want.sx) begin
                $display("%0t: screen_x exp %0d got %0d", $time, want.sx, got.sx);
                errors++;
            end
            if (got.sy !== want.sy) begin
                $display("%0t: screen_y exp %0d got %0d", $time, want.sy, got.sy);
                errors++;
            end
            if (got.u !== want.u) begin
                $display("%0t: tex_u exp %0d got %0d", $time, want.u, got.u);
                errors++;
            end
            if (got.v !== want.v) begin
                $display("%0t: tex_v exp %0d got %0d", $time, want.v, got.v);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 0;
    logic [12:0] cfg_data = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_command = 0;
    logic [2:0]  s_slot = 0;
    logic [31:0] s_first_id = 0;
    logic [31:0] s_last_id = 0;
    logic [12:0] s_sheet_columns = 0;
    logic [8:0]  s_tile_width = 0;
    logic [8:0]  s_tile_height = 0;
    logic [31:0] s_tile_id = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [2:0]  m_set_index;
    logic [23:0] m_sequence_res;
    logic [2:0]  m_corner;
    logic [20:0] m_screen_x;
    logic [20:0] m_screen_y;
    logic [32:0] m_tex_u;
    logic [32:0] m_tex_v;
    logic        m_last;

    int unsigned    send_idle = 0;
    int unsigned    recv_idle = 0;
    quad_scoreboard sb = new();

    tile_map_quad_generator_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_slot(s_slot),
        .s_first_id(s_first_id), .s_last_id(s_last_id),
        .s_sheet_columns(s_sheet_columns),
        .s_tile_width(s_tile_width), .s_tile_height(s_tile_height),
        .s_tile_id(s_tile_id),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_set_index(m_set_index), .m_sequence_res(m_sequence_res),
        .m_corner(m_corner), .m_screen_x(m_screen_x), .m_screen_y(m_screen_y),
        .m_tex_u(m_tex_u), .m_tex_v(m_tex_v), .m_last(m_last)
    );

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_set_index, m_sequence_res, m_corner, m_screen_x,
                             m_screen_y, m_tex_u, m_tex_v, m_last});
        m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    initial begin
        #2000000;
        $display("[tile_map_quad_generator_core] ERROR");
        $finish;
    end

    task automatic send_item(tile_item_t it);
        if ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle) @(posedge aclk);
        end
        s_valid         <= 1;
        s_command       <= it.command;
        s_slot          <= it.slot;
        s_first_id      <= it.first_id;
        s_last_id       <= it.last_id;
        s_sheet_columns <= it.sheet_columns;
        s_tile_width    <= it.tile_width;
        s_tile_height   <= it.tile_height;
        s_tile_id       <= it.tile_id;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
    endtask

    task automatic load_slot(logic [2:0] slot, logic [31:0] first, logic [31:0] last,
                             logic [12:0] cols, logic [8:0] tw, logic [8:0] th);
        tile_item_t it;
        it = '0;
        it.command = CMD_LOAD;
        it.slot = slot;
        it.first_id = first;
        it.last_id = last;
        it.sheet_columns = cols;
        it.tile_width = tw;
        it.tile_height = th;
        it.tile_id = $urandom;
        send_item(it);
    endtask

    task automatic send_cmd(logic [1:0] cmd, logic [31:0] id);
        tile_item_t it;
        it = '0;
        it.command = cmd;
        it.tile_id = id;
        it.slot = 3'($urandom);
        it.first_id = $urandom;
        it.last_id = $urandom;
        send_item(it);
    endtask

    // block is drained: no vertex outstanding and the back stage has settled
    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [12:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic set_map(logic [12:0] w, logic [12:0] h, logic [12:0] cnt);
        write_cfg(REG_MAP_WIDTH, w);
        write_cfg(REG_MAP_HEIGHT, h);
        write_cfg(REG_SET_COUNT, cnt);
        write_cfg(REG_UNUSED, 13'($urandom));
        cfg_valid <= 0;
    endtask

    task automatic random_load();
        logic [31:0] first, last;
        logic [12:0] cols;
        case ($urandom_range(0, 3))
            0: first = $urandom;
            1: first = $urandom_range(1, 5000);
            2: first = 32'hFFFF_FFFF - $urandom_range(0, 300);
            default: first = $urandom_range(0, 3);
        endcase
        case ($urandom_range(0, 4))
            0: last = $urandom;
            1: last = first - $urandom_range(1, 10);
            2: last = 32'hFFFF_FFFF;
            default: last = first + $urandom_range(0, 2000);
        endcase
        case ($urandom_range(0, 5))
            0: cols = 13'd0;
            1: cols = 13'($urandom);
            default: cols = 13'($urandom_range(1, 16));
        endcase
        load_slot(3'($urandom), first, last, cols, 9'($urandom), 9'($urandom));
    endtask

    task automatic random_tile();
        logic [31:0] id;
        int unsigned s, cnt;
        logic [63:0] span;
        cnt = sb.eff_count();
        if (cnt > 0 && $urandom_range(0, 99) < 80) begin
            s = $urandom_range(0, cnt - 1);
            if (sb.last_id[s] >= sb.first_id[s]) begin
                span = 64'(sb.last_id[s] - sb.first_id[s]) + 1;
                id = sb.first_id[s] + 32'({$urandom, $urandom} % span);
            end else begin
                id = sb.first_id[s];
            end
        end else if ($urandom_range(0, 1)) begin
            id = 0;
        end else begin
            id = $urandom;
        end
        send_cmd(CMD_TILE, id);
    endtask

    initial begin
        logic [12:0] w, h, cnt;
        int unsigned r, n;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // no slot in use yet
        send_cmd(CMD_TILE, 5);
        load_slot(0, 1, 100, 10, 16, 16);
        load_slot(1, 50, 60, 1, 256, 256);
        load_slot(2, 32'hFFFF_FF00, 32'hFFFF_FFFF, 4096, 511, 511);
        load_slot(3, 200, 300, 0, 8, 8);
        load_slot(4, 0, 0, 5, 4, 4);
        load_slot(5, 400, 500, 3, 0, 0);
        load_slot(6, 1000, 2000, 8191, 255, 1);
        load_slot(7, 32'h8000_0000, 32'h8000_FFFF, 7, 300, 2);
        drain();
        set_map(3, 2, 8);
        send_cmd(CMD_BEGIN, 0);
        send_cmd(CMD_TILE, 0);
        send_cmd(CMD_TILE, 5);
        send_cmd(CMD_TILE, 55);
        send_cmd(CMD_TILE, 32'hFFFF_FFFF);
        send_cmd(CMD_TILE, 250);
        send_cmd(CMD_TILE, 450);
        // past the map
        send_cmd(CMD_TILE, 1500);
        send_cmd(CMD_UNUSED, 7);
        send_cmd(CMD_BEGIN, 0);
        send_cmd(CMD_TILE, 32'h8000_1000);
        send_cmd(CMD_TILE, 32'h8000_0123);
        send_cmd(CMD_TILE, 1);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph / 3)
                0: begin send_idle = 26; recv_idle = 56; end
                1: begin send_idle = 56; recv_idle = 26; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            case (ph)
                0: begin w = 0; h = 8191; cnt = 15; end
                1: begin w = 4096; h = 0; cnt = 1; end
                2: begin w = 8191; h = 4096; cnt = 0; end
                default: begin
                    w = $urandom_range(0, 1) ? 13'($urandom_range(1, 6)) : 13'($urandom);
                    h = $urandom_range(0, 3) ? 13'($urandom_range(1, 12)) : 13'($urandom);
                    cnt = 13'($urandom_range(1, 15));
                end
            endcase
            set_map(w, h, cnt);
            send_cmd(CMD_BEGIN, 0);
            n = (ph == 1) ? 10 : 38;
            for (int k = 0; k < n; k++) begin
                r = $urandom_range(0, 99);
                if (r < 8) random_load();
                else if (r < 11) send_cmd(CMD_BEGIN, $urandom);
                else if (r < 13) send_cmd(CMD_UNUSED, $urandom);
                else random_tile();
            end
            drain();
        end

        if (sb.errors == 0)
            $display("[tile_map_quad_generator_core] OK");
        else
            $display("[tile_map_quad_generator_core] ERROR");
        $finish;
    end
endmodule
